// ----- sv/bicycle_model_pose_predict_core_macros.svh -----
// Assertion helpers shared by the pose predictor sources.
// All checks run on clk and are disabled while rst is high.
`ifndef BICYCLE_MODEL_POSE_PREDICT_CORE_MACROS_SVH
`define BICYCLE_MODEL_POSE_PREDICT_CORE_MACROS_SVH

// Same-cycle implication
`define BMPP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BMPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Invariant on every clock edge
`define BMPP_ASSERT_ALWAYS(label, cond, msg) \
  `BMPP_ASSERT_IMPLY(label, 1'b1, cond, msg)

`endif

// ----- sv/bmpp_pkg.sv -----
package bmpp_pkg;

  // Step table geometry
  localparam int MAX_STEPS = 64;
  localparam int STEP_AW   = $clog2(MAX_STEPS);

  // Request kinds
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_PREDICT = 1'b1;

  // Fixed point formats
  localparam int FRAC_BITS    = 16;
  localparam int Q30_SHIFT    = 30;
  localparam int CORDIC_ITERS = 30;

  // Angle in Q30: a 32-bit Q16.16 value shifted up by 14
  localparam int ANG_W = 46;
  typedef logic signed [ANG_W-1:0] ang_t;

  // Range reduction: conditional subtracts of 2*pi shifted by 13 down to 0
  localparam int RED_STEPS = 14;

  // Divider numerator: sin in Q30 shifted up by FRAC_BITS
  localparam int NUM_W = 48;
  typedef logic signed [NUM_W-1:0] num_t;

  // 1/1.28 = 25/32
  localparam int INV_WB_SHIFT = 5;

  localparam logic [ANG_W-1:0]    TWO_PI_MAG  = 46'd6746518852;
  localparam logic signed [35:0]  PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0]  HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0]  TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [33:0]  GAIN_Q30    = 34'sd652032874;
  localparam logic signed [31:0]  SAT_MAX     = 32'sh7fffffff;
  localparam logic signed [31:0]  SAT_MIN     = 32'sh80000000;

  // One control step as held in the table
  typedef struct packed {
    logic signed [31:0] t;
    logic signed [31:0] v;
    logic signed [17:0] phi;
  } step_entry_t;

  // atan(2^-i) in Q30; beyond the table it is 2^(30-i) - 1
  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic [35:0] one;
    one = 36'd1;
    case (i)
      5'd0:    atan_q30 = 36'sd843314856;
      5'd1:    atan_q30 = 36'sd497837829;
      5'd2:    atan_q30 = 36'sd263043836;
      5'd3:    atan_q30 = 36'sd133525158;
      5'd4:    atan_q30 = 36'sd67021686;
      5'd5:    atan_q30 = 36'sd33543515;
      5'd6:    atan_q30 = 36'sd16775850;
      5'd7:    atan_q30 = 36'sd8388437;
      5'd8:    atan_q30 = 36'sd4194282;
      5'd9:    atan_q30 = 36'sd2097149;
      default: atan_q30 = $signed((one << (5'(Q30_SHIFT) - i)) - 36'd1);
    endcase
  endfunction

  // Saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = SAT_MAX;
    end else if (v < -64'sd2147483648) begin
      sat32 = SAT_MIN;
    end else begin
      sat32 = $signed(v[31:0]);
    end
  endfunction

endpackage

// ----- sv/bmpp_step_ram.sv -----
module bmpp_step_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [bmpp_pkg::STEP_AW-1:0]      wr_addr,
  input  bmpp_pkg::step_entry_t             wr_data,
  input  logic [bmpp_pkg::STEP_AW-1:0]      rd_addr,
  output bmpp_pkg::step_entry_t             rd_data
);

  bmpp_pkg::step_entry_t mem [bmpp_pkg::MAX_STEPS];

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/bmpp_cordic.sv -----
module bmpp_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  bmpp_pkg::ang_t     angle,
  output logic               done,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);

  typedef enum logic [2:0] {S_IDLE, S_REDUCE, S_WRAP, S_ITER, S_FIN} state_t;

  state_t                           state;
  logic [bmpp_pkg::ANG_W-1:0]       mag;
  logic                             neg;
  logic [3:0]                       k;
  logic                             flip;
  logic signed [35:0]               r;
  logic signed [33:0]               x;
  logic signed [33:0]               y;
  logic [4:0]                       i;

  logic [bmpp_pkg::ANG_W:0]         red_sub;
  logic signed [35:0]               r0;
  logic signed [35:0]               r1;
  logic signed [35:0]               r_wrap;
  logic                             flip_wrap;
  logic signed [33:0]               x_sh;
  logic signed [33:0]               y_sh;
  logic signed [35:0]               atan_i;

  // Reduction trial, wrap to [-pi, pi], fold to [-pi/2, pi/2]
  always_comb begin
    red_sub = {1'b0, mag} - ({1'b0, bmpp_pkg::TWO_PI_MAG} << k);
    // after reduction mag < 2*pi, so 33 bits hold it
    r0 = $signed({3'b000, mag[32:0]});
    if (neg) begin
      r0 = -r0;
    end
    r1 = r0;
    if (r0 > bmpp_pkg::PI_Q30) begin
      r1 = r0 - bmpp_pkg::TWO_PI_Q30;
    end else if (r0 < -bmpp_pkg::PI_Q30) begin
      r1 = r0 + bmpp_pkg::TWO_PI_Q30;
    end
    r_wrap    = r1;
    flip_wrap = 1'b0;
    if (r1 > bmpp_pkg::HALF_PI_Q30) begin
      r_wrap    = r1 - bmpp_pkg::PI_Q30;
      flip_wrap = 1'b1;
    end else if (r1 < -bmpp_pkg::HALF_PI_Q30) begin
      r_wrap    = r1 + bmpp_pkg::PI_Q30;
      flip_wrap = 1'b1;
    end
    x_sh   = x >>> i;
    y_sh   = y >>> i;
    atan_i = bmpp_pkg::atan_q30(i);
  end

  // Sequencer: magnitude remainder, wrap, rotations, result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            neg   <= angle[bmpp_pkg::ANG_W-1];
            mag   <= angle[bmpp_pkg::ANG_W-1] ? (~angle + 1'b1) : angle;
            k     <= 4'(bmpp_pkg::RED_STEPS - 1);
            state <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (!red_sub[bmpp_pkg::ANG_W]) begin
            mag <= red_sub[bmpp_pkg::ANG_W-1:0];
          end
          if (k == 4'd0) begin
            state <= S_WRAP;
          end else begin
            k <= k - 4'd1;
          end
        end
        S_WRAP: begin
          r     <= r_wrap;
          flip  <= flip_wrap;
          x     <= bmpp_pkg::GAIN_Q30;
          y     <= '0;
          i     <= '0;
          state <= S_ITER;
        end
        S_ITER: begin
          if (r >= 0) begin
            x <= x - y_sh;
            y <= y + x_sh;
            r <= r - atan_i;
          end else begin
            x <= x + y_sh;
            y <= y - x_sh;
            r <= r + atan_i;
          end
          if (i == 5'(bmpp_pkg::CORDIC_ITERS - 1)) begin
            state <= S_FIN;
          end else begin
            i <= i + 5'd1;
          end
        end
        S_FIN: begin
          sin_q <= flip ? 32'(-y) : 32'(y);
          cos_q <= flip ? 32'(-x) : 32'(x);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/bmpp_div.sv -----
module bmpp_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  bmpp_pkg::num_t     num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

  state_t                           state;
  logic [bmpp_pkg::NUM_W-1:0]       a;
  logic [31:0]                      b;
  logic [31:0]                      rem;
  logic [bmpp_pkg::NUM_W-1:0]       q;
  logic [5:0]                       cnt;
  logic                             neg;
  logic                             num_neg;
  logic                             den_zero;

  logic [32:0]                      trial;
  logic signed [bmpp_pkg::NUM_W:0]  q_signed;

  // One restoring step, and the signed quotient
  always_comb begin
    trial    = {rem, a[bmpp_pkg::NUM_W-1]};
    q_signed = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  // Magnitude division, one quotient bit a cycle, truncating toward zero
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            a        <= num[bmpp_pkg::NUM_W-1] ? (~num + 1'b1) : num;
            b        <= den[31] ? (~den + 1'b1) : den;
            rem      <= '0;
            q        <= '0;
            cnt      <= '0;
            neg      <= num[bmpp_pkg::NUM_W-1] ^ den[31];
            num_neg  <= num[bmpp_pkg::NUM_W-1];
            den_zero <= (den == '0);
            state    <= S_RUN;
          end
        end
        S_RUN: begin
          if (trial >= {1'b0, b}) begin
            rem <= 32'(trial - {1'b0, b});
            q   <= {q[bmpp_pkg::NUM_W-2:0], 1'b1};
          end else begin
            rem <= trial[31:0];
            q   <= {q[bmpp_pkg::NUM_W-2:0], 1'b0};
          end
          a <= a << 1;
          if (cnt == 6'(bmpp_pkg::NUM_W - 1)) begin
            state <= S_FIN;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_FIN: begin
          // zero divisor gives the extreme with the numerator's sign
          if (den_zero) begin
            quot <= num_neg ? bmpp_pkg::SAT_MIN : bmpp_pkg::SAT_MAX;
          end else begin
            quot <= bmpp_pkg::sat32(64'(q_signed));
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/bicycle_model_pose_predict_core.sv -----
// Kinematic bicycle pose predictor, forward Euler over the step table.
// Load: writes one table entry, no result. Predict: per control step, a table
// read, the two CORDIC units in parallel, the divider and the multiply phases;
// the next request is taken once the result is registered, and the result
// waits in ST_OUT while the previous one is not taken.
// Reset: step_count is 1, the step table is undefined until written.
`include "bicycle_model_pose_predict_core_macros.svh"

module bicycle_model_pose_predict_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [5:0]         step_index,
  input  logic signed [31:0] step_time,
  input  logic signed [31:0] speed,
  input  logic signed [17:0] steer_angle,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] start_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pred_x,
  output logic signed [31:0] pred_z,
  output logic signed [31:0] pred_heading,
  output logic signed [31:0] rate_x,
  output logic signed [31:0] rate_z,
  output logic signed [31:0] rate_heading,
  output logic signed [31:0] last_speed,
  output logic signed [17:0] last_steer
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_LATCH, ST_TRIG, ST_DIV, ST_MUL, ST_OUT
  } state_t;

  // Multiply schedule: operands of each phase, the result used one phase on
  typedef enum logic [2:0] {
    MP_TV, MP_CV, MP_SV, MP_DHT, MP_DXT, MP_DZT, MP_LAST
  } mul_phase_t;

  state_t                           state;
  mul_phase_t                       mp;
  logic [6:0]                       step_count;
  logic [bmpp_pkg::STEP_AW-1:0]     j;
  logic [bmpp_pkg::STEP_AW-1:0]     last;
  logic [bmpp_pkg::STEP_AW-1:0]     last_next;

  logic signed [31:0]               x, z, h;
  logic signed [31:0]               t, v;
  logic signed [17:0]               phi;
  logic signed [31:0]               sh, ch, tn;
  logic signed [31:0]               dx, dz, dh;
  logic signed [63:0]               prod;

  logic signed [31:0]               mul_a, mul_b;
  logic signed [63:0]               p64, p25, dh_wide;

  logic                             ram_we;
  bmpp_pkg::step_entry_t            ram_wdata;
  bmpp_pkg::step_entry_t            ram_rdata;

  logic                             cordic_start;
  bmpp_pkg::ang_t                   ang_h, ang_p;
  logic                             done_h, done_p;
  logic signed [31:0]               sin_h, cos_h, sin_p, cos_p;

  logic                             div_start, div_done;
  bmpp_pkg::num_t                   div_num;
  logic signed [31:0]               div_quot;

  assign in_ready = (state == ST_IDLE) && !rst;

  // Table writes on a load transfer
  assign ram_we    = in_valid && in_ready && (req_type == bmpp_pkg::REQ_LOAD) &&
                     ({1'b0, step_index} < 7'(bmpp_pkg::MAX_STEPS));
  assign ram_wdata = '{t: step_time, v: speed, phi: steer_angle};

  bmpp_step_ram u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (step_index[bmpp_pkg::STEP_AW-1:0]),
    .wr_data (ram_wdata),
    .rd_addr (j),
    .rd_data (ram_rdata)
  );

  // Heading and steering angles into Q30
  assign cordic_start = (state == ST_LATCH);
  assign ang_h = bmpp_pkg::ang_t'(h) <<< (bmpp_pkg::Q30_SHIFT - bmpp_pkg::FRAC_BITS);
  assign ang_p = bmpp_pkg::ang_t'(ram_rdata.phi)
                 <<< (bmpp_pkg::Q30_SHIFT - bmpp_pkg::FRAC_BITS);

  bmpp_cordic u_cordic_h (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (ang_h),
    .done  (done_h),
    .sin_q (sin_h),
    .cos_q (cos_h)
  );

  bmpp_cordic u_cordic_p (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (ang_p),
    .done  (done_p),
    .sin_q (sin_p),
    .cos_q (cos_p)
  );

  // tan(phi) = (sin << FRAC_BITS) / cos
  assign div_start = (state == ST_TRIG) && done_h;
  assign div_num   = bmpp_pkg::num_t'(sin_p) <<< bmpp_pkg::FRAC_BITS;

  bmpp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (cos_p),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Step count clamped to [1, MAX_STEPS], held as last index
  always_comb begin
    if (step_count == 7'd0) begin
      last_next = '0;
    end else if (step_count > 7'(bmpp_pkg::MAX_STEPS)) begin
      last_next = bmpp_pkg::STEP_AW'(bmpp_pkg::MAX_STEPS - 1);
    end else begin
      last_next = bmpp_pkg::STEP_AW'(step_count - 7'd1);
    end
  end

  // Shared multiplier operands
  always_comb begin
    case (mp)
      MP_TV:   begin mul_a = tn; mul_b = v; end
      MP_CV:   begin mul_a = ch; mul_b = v; end
      MP_SV:   begin mul_a = sh; mul_b = v; end
      MP_DHT:  begin mul_a = dh; mul_b = t; end
      MP_DXT:  begin mul_a = dx; mul_b = t; end
      default: begin mul_a = dz; mul_b = t; end
    endcase
  end

  // dh = -((tan*v >> FRAC) * 25 >> 5); times 25 as 16 + 8 + 1
  always_comb begin
    p64     = prod >>> bmpp_pkg::FRAC_BITS;
    p25     = (p64 <<< 4) + (p64 <<< 3) + p64;
    dh_wide = -(p25 >>> bmpp_pkg::INV_WB_SHIFT);
  end

  // Step count register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= 7'd1;
    end else if (cfg_wr_en) begin
      step_count <= cfg_wr_data;
    end
  end

  // Prediction sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mp        <= MP_TV;
      j         <= '0;
      last      <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result in ST_OUT takes over the register itself
      if (out_valid && out_ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && (req_type == bmpp_pkg::REQ_PREDICT)) begin
            x     <= start_x;
            z     <= start_z;
            h     <= start_heading;
            j     <= '0;
            last  <= last_next;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_LATCH;
        end
        ST_LATCH: begin
          t     <= ram_rdata.t;
          v     <= ram_rdata.v;
          phi   <= ram_rdata.phi;
          state <= ST_TRIG;
        end
        ST_TRIG: begin
          if (done_h) begin
            sh    <= sin_h;
            ch    <= cos_h;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            tn    <= div_quot;
            mp    <= MP_TV;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod <= mul_a * mul_b;
          mp   <= mul_phase_t'(mp + 3'd1);
          case (mp)
            MP_CV:  dh <= bmpp_pkg::sat32(dh_wide);
            MP_SV:  dx <= bmpp_pkg::sat32(prod >>> bmpp_pkg::Q30_SHIFT);
            MP_DHT: dz <= bmpp_pkg::sat32(prod >>> bmpp_pkg::Q30_SHIFT);
            MP_DXT: h  <= bmpp_pkg::sat32(64'(h) + (prod >>> bmpp_pkg::FRAC_BITS));
            MP_DZT: x  <= bmpp_pkg::sat32(64'(x) + (prod >>> bmpp_pkg::FRAC_BITS));
            MP_LAST: begin
              z <= bmpp_pkg::sat32(64'(z) + (prod >>> bmpp_pkg::FRAC_BITS));
              if (j == last) begin
                state <= ST_OUT;
              end else begin
                j     <= j + 1'b1;
                state <= ST_READ;
              end
            end
            default: ;
          endcase
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            pred_x       <= x;
            pred_z       <= z;
            pred_heading <= h;
            rate_x       <= dx;
            rate_z       <= dz;
            rate_heading <= dh;
            last_speed   <= v;
            last_steer   <= phi;
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `BMPP_ASSERT_ALWAYS(a_cordic_lockstep, done_h == done_p, "CORDIC units out of step")
  `BMPP_ASSERT_IMPLY(a_div_done_in_div, div_done, state == ST_DIV, "divider done off phase")
  `BMPP_ASSERT_NEXT(a_out_held, (state == ST_OUT) && out_valid && !out_ready, state == ST_OUT, "result overwritten")
  `BMPP_ASSERT_IMPLY(a_step_bound, state != ST_IDLE, j <= last, "step index past count")

endmodule
